@@ src/mi3_pkg.sv @@
// shared widths, types and register codes for the 3x3 matrix inverse
package mi3_pkg;

   localparam int ELEM_BITS = 32;
   localparam int FRAC_BITS = 16;
   localparam int THR_BITS  = 31;

   localparam int PROD_BITS     = 2 * ELEM_BITS;
   localparam int COF_BITS      = 2 * ELEM_BITS + 1;
   localparam int CMAG_BITS     = 2 * ELEM_BITS;
   localparam int DET_BITS      = 3 * ELEM_BITS + 1;
   localparam int DMAG_BITS     = 3 * ELEM_BITS;
   localparam int QUO_BITS      = ELEM_BITS + 1;
   localparam int REM_BITS      = DMAG_BITS + 1;
   localparam int NUM_BITS      = CMAG_BITS + 2 * FRAC_BITS;
   localparam int DIV_CMP_BITS  = NUM_BITS + REM_BITS;
   localparam int SING_CMP_BITS = DMAG_BITS + THR_BITS + 2 * FRAC_BITS;

   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_AW    = 1;

   localparam int CSR_AW        = 3;
   localparam int CSR_DATA_BITS = 32;
   localparam logic REG_THRESHOLD = 1'b0;
   localparam logic [THR_BITS-1:0] THR_RESET = THR_BITS'(1);

   typedef logic [ELEM_BITS-1:0] elem_type;
   typedef elem_type [8:0] mat_type;

   typedef struct packed {
      logic [CMAG_BITS-1:0] cmag;
      logic                 neg;
   } cls_lane_type;

   typedef struct packed {
      cls_lane_type [8:0]   lane;
      logic [DMAG_BITS-1:0] dmag;
      logic                 sing;
   } cls_item_type;

   typedef struct packed {
      logic [REM_BITS-1:0] rem;
      logic [QUO_BITS-1:0] quo;
      logic [QUO_BITS-1:0] nbits;
      logic                big;
      logic                neg;
   } dlane_type;

   typedef struct packed {
      dlane_type [8:0]      lane;
      logic [DMAG_BITS-1:0] dmag;
      logic                 sing;
   } dstage_type;

endpackage

@@ src/mi3_front.sv @@
// front pipeline: cofactors, determinant and singular classification
module mi3_front import mi3_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_ready,
   input  mat_type             in_mat,
   input  logic [THR_BITS-1:0] thr,
   output logic                out_valid,
   input  logic                out_ready,
   output cls_item_type        out_item
);

   logic [5:0] v_ff;
   logic       en;

   mat_type                     mat_ff;
   logic signed [PROD_BITS-1:0] prod_ff [18];
   logic signed [PROD_BITS-1:0] prod_in [18];
   elem_type                    r0a_ff [3];
   elem_type                    r0b_ff [3];
   logic signed [COF_BITS-1:0]  cof2_ff [9];
   logic signed [COF_BITS-1:0]  cof2_in [9];
   logic signed [COF_BITS-1:0]  cof3_ff [9];
   logic signed [COF_BITS-1:0]  cof4_ff [9];
   logic signed [PROD_BITS:0]   plo_ff [3];
   logic signed [PROD_BITS:0]   plo_in [3];
   logic signed [PROD_BITS:0]   phi_ff [3];
   logic signed [PROD_BITS:0]   phi_in [3];
   logic signed [DET_BITS-1:0]  det_ff;
   logic signed [DET_BITS-1:0]  det_in;
   cls_item_type                cls_ff;
   cls_item_type                cls_in;

   assign en        = !(v_ff[5] && !out_ready);
   assign in_ready  = en;
   assign out_valid = v_ff[5];
   assign out_item  = cls_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (en) begin
         v_ff <= {v_ff[4:0], in_valid};
      end
   end

   // minors of the 2x2 submatrices, two products each
   always_comb begin
      int i1, i2, j1, j2;
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 3; j++) begin
            i1 = (i == 0) ? 1 : 0;
            i2 = (i == 2) ? 1 : 2;
            j1 = (j == 0) ? 1 : 0;
            j2 = (j == 2) ? 1 : 2;
            prod_in[2*(i*3+j)]   = $signed(mat_ff[i1*3+j1]) * $signed(mat_ff[i2*3+j2]);
            prod_in[2*(i*3+j)+1] = $signed(mat_ff[i1*3+j2]) * $signed(mat_ff[i2*3+j1]);
         end
      end
   end

   always_comb begin
      logic signed [COF_BITS-1:0] d;
      for (int k = 0; k < 9; k++) begin
         d = $signed({prod_ff[2*k][PROD_BITS-1], prod_ff[2*k]})
           - $signed({prod_ff[2*k+1][PROD_BITS-1], prod_ff[2*k+1]});
         cof2_in[k] = (((k / 3) + (k % 3)) % 2 == 1) ? -d : d;
      end
   end

   // row 0 times its cofactors, cofactor split into low and high halves
   always_comb begin
      for (int j = 0; j < 3; j++) begin
         plo_in[j] = $signed(r0b_ff[j]) * $signed({1'b0, cof2_ff[j][ELEM_BITS-1:0]});
         phi_in[j] = $signed(r0b_ff[j]) * $signed(cof2_ff[j][COF_BITS-1:ELEM_BITS]);
      end
   end

   always_comb begin
      logic signed [DET_BITS-1:0] acc;
      acc = '0;
      for (int j = 0; j < 3; j++) begin
         acc = acc + $signed({phi_ff[j], {ELEM_BITS{1'b0}}})
                   + $signed({{ELEM_BITS{plo_ff[j][PROD_BITS]}}, plo_ff[j]});
      end
      det_in = acc;
   end

   always_comb begin
      logic [DET_BITS-1:0]      dn;
      logic [DMAG_BITS-1:0]     dmag;
      logic [SING_CMP_BITS-1:0] thr_ext;
      logic [SING_CMP_BITS-1:0] det_ext;
      logic [COF_BITS-1:0]      cn;
      dn      = det_ff[DET_BITS-1] ? -det_ff : det_ff;
      dmag    = dn[DMAG_BITS-1:0];
      thr_ext = SING_CMP_BITS'({thr, {(2*FRAC_BITS){1'b0}}});
      det_ext = SING_CMP_BITS'(dmag);
      cls_in.dmag = dmag;
      cls_in.sing = (dmag == '0) || (det_ext < thr_ext);
      // transpose: result (i,j) takes cofactor (j,i)
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 3; j++) begin
            cn = cof4_ff[j*3+i][COF_BITS-1] ? -cof4_ff[j*3+i] : cof4_ff[j*3+i];
            cls_in.lane[i*3+j].cmag = cn[CMAG_BITS-1:0];
            cls_in.lane[i*3+j].neg  = cof4_ff[j*3+i][COF_BITS-1] ^ det_ff[DET_BITS-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         mat_ff  <= in_mat;
         prod_ff <= prod_in;
         for (int j = 0; j < 3; j++) begin
            r0a_ff[j] <= mat_ff[j];
            r0b_ff[j] <= r0a_ff[j];
         end
         cof2_ff <= cof2_in;
         plo_ff  <= plo_in;
         phi_ff  <= phi_in;
         cof3_ff <= cof2_ff;
         det_ff  <= det_in;
         cof4_ff <= cof3_ff;
         cls_ff  <= cls_in;
      end
   end

endmodule

@@ src/mi3_queue.sv @@
// short fifo between the classification front and the divider back
module mi3_queue import mi3_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         push_valid,
   output logic         push_ready,
   input  cls_item_type push_item,
   output logic         pop_valid,
   input  logic         pop_ready,
   output cls_item_type pop_item
);

   cls_item_type          mem_ff [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0]   wr_ptr_ff;
   logic [QUEUE_AW-1:0]   rd_ptr_ff;
   logic [QUEUE_AW:0]     cnt_ff;
   logic                  push;
   logic                  pop;

   assign push_ready = (cnt_ff != (QUEUE_AW+1)'(QUEUE_DEPTH));
   assign pop_valid  = (cnt_ff != '0);
   assign pop_item   = mem_ff[rd_ptr_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         if (push) wr_ptr_ff <= wr_ptr_ff + 1'b1;
         if (pop)  rd_ptr_ff <= rd_ptr_ff + 1'b1;
         unique case ({push, pop})
            2'b10:   cnt_ff <= cnt_ff + 1'b1;
            2'b01:   cnt_ff <= cnt_ff - 1'b1;
            default: cnt_ff <= cnt_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (push) mem_ff[wr_ptr_ff] <= push_item;
   end

endmodule

@@ src/mi3_back.sv @@
// back pipeline: one restoring division step per stage, rounding and saturation
module mi3_back import mi3_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         in_valid,
   output logic         in_ready,
   input  cls_item_type in_item,
   output logic         out_valid,
   input  logic         out_ready,
   output mat_type      out_mat,
   output logic         out_sing
);

   logic       en;
   logic       vld_ff [QUO_BITS+1];
   dstage_type st_ff  [QUO_BITS+1];
   dstage_type st_in  [QUO_BITS+1];
   logic       ov_ff;
   mat_type    res_ff;
   mat_type    res_in;
   logic       sing_ff;

   assign en        = !ov_ff || out_ready;
   assign in_ready  = en;
   assign out_valid = ov_ff;
   assign out_mat   = res_ff;
   assign out_sing  = sing_ff;

   // quotient is limited to QUO_BITS bits; anything larger saturates anyway
   always_comb begin
      logic [NUM_BITS-1:0]     nfull;
      logic [DIV_CMP_BITS-1:0] hi_ext;
      logic [DIV_CMP_BITS-1:0] d_ext;
      logic [REM_BITS-1:0]     trial;
      logic [REM_BITS-1:0]     dw;
      logic                    ge;
      st_in[0].dmag = in_item.dmag;
      st_in[0].sing = in_item.sing;
      d_ext = DIV_CMP_BITS'(in_item.dmag);
      for (int l = 0; l < 9; l++) begin
         nfull  = {in_item.lane[l].cmag, {(2*FRAC_BITS){1'b0}}};
         hi_ext = DIV_CMP_BITS'(nfull >> QUO_BITS);
         st_in[0].lane[l].big   = (hi_ext >= d_ext);
         st_in[0].lane[l].rem   = hi_ext[REM_BITS-1:0];
         st_in[0].lane[l].nbits = nfull[QUO_BITS-1:0];
         st_in[0].lane[l].quo   = '0;
         st_in[0].lane[l].neg   = in_item.lane[l].neg;
      end
      for (int s = 0; s < QUO_BITS; s++) begin
         st_in[s+1].dmag = st_ff[s].dmag;
         st_in[s+1].sing = st_ff[s].sing;
         dw = {1'b0, st_ff[s].dmag};
         for (int l = 0; l < 9; l++) begin
            trial = {st_ff[s].lane[l].rem[REM_BITS-2:0], st_ff[s].lane[l].nbits[QUO_BITS-1]};
            ge    = (trial >= dw);
            st_in[s+1].lane[l].rem   = ge ? trial - dw : trial;
            st_in[s+1].lane[l].quo   = {st_ff[s].lane[l].quo[QUO_BITS-2:0], ge};
            st_in[s+1].lane[l].nbits = {st_ff[s].lane[l].nbits[QUO_BITS-2:0], 1'b0};
            st_in[s+1].lane[l].big   = st_ff[s].lane[l].big;
            st_in[s+1].lane[l].neg   = st_ff[s].lane[l].neg;
         end
      end
   end

   // round half away from zero, then clamp to the element range
   always_comb begin
      logic                rnd;
      logic [QUO_BITS:0]   qr;
      logic [QUO_BITS:0]   nq;
      dlane_type           ln;
      for (int l = 0; l < 9; l++) begin
         ln  = st_ff[QUO_BITS].lane[l];
         rnd = ({ln.rem, 1'b0} >= {2'b00, st_ff[QUO_BITS].dmag});
         qr  = {1'b0, ln.quo} + {{QUO_BITS{1'b0}}, rnd};
         nq  = -qr;
         if (st_ff[QUO_BITS].sing) begin
            res_in[l] = '0;
         end else if (ln.neg) begin
            if (ln.big || qr > {2'b00, 1'b1, {(ELEM_BITS-1){1'b0}}})
               res_in[l] = {1'b1, {(ELEM_BITS-1){1'b0}}};
            else
               res_in[l] = nq[ELEM_BITS-1:0];
         end else begin
            if (ln.big || qr > {3'b000, {(ELEM_BITS-1){1'b1}}})
               res_in[l] = {1'b0, {(ELEM_BITS-1){1'b1}}};
            else
               res_in[l] = qr[ELEM_BITS-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s <= QUO_BITS; s++) vld_ff[s] <= 1'b0;
         ov_ff <= 1'b0;
      end else if (en) begin
         vld_ff[0] <= in_valid;
         for (int s = 0; s < QUO_BITS; s++) vld_ff[s+1] <= vld_ff[s];
         ov_ff <= vld_ff[QUO_BITS];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int s = 0; s <= QUO_BITS; s++) st_ff[s] <= st_in[s];
         res_ff  <= res_in;
         sing_ff <= st_ff[QUO_BITS].sing;
      end
   end

endmodule

@@ src/matrix_inverse_3x3_top.sv @@
// top level of the 3x3 matrix inverse with threshold register
// Inverts one signed Q16.16 3x3 matrix per request by the adjugate method: a six-stage
// front forms the cofactors, the exact determinant and the singular flag (|det| below the
// threshold register, or zero), a two-entry queue decouples it from the back, and the back
// divides each adjugate entry by the determinant in a pipeline of one quotient bit per stage
// (33 stages for the nine entries in parallel), then rounds and saturates. One request is
// taken every cycle while the response side keeps up. Singular matrices return zeros with
// singular set. The threshold lives at byte address 0 and may be written only while no
// request is in flight.
module matrix_inverse_3x3_top import mi3_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic [ELEM_BITS-1:0]     req_a00,
   input  logic [ELEM_BITS-1:0]     req_a01,
   input  logic [ELEM_BITS-1:0]     req_a02,
   input  logic [ELEM_BITS-1:0]     req_a10,
   input  logic [ELEM_BITS-1:0]     req_a11,
   input  logic [ELEM_BITS-1:0]     req_a12,
   input  logic [ELEM_BITS-1:0]     req_a20,
   input  logic [ELEM_BITS-1:0]     req_a21,
   input  logic [ELEM_BITS-1:0]     req_a22,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic [ELEM_BITS-1:0]     rsp_r00,
   output logic [ELEM_BITS-1:0]     rsp_r01,
   output logic [ELEM_BITS-1:0]     rsp_r02,
   output logic [ELEM_BITS-1:0]     rsp_r10,
   output logic [ELEM_BITS-1:0]     rsp_r11,
   output logic [ELEM_BITS-1:0]     rsp_r12,
   output logic [ELEM_BITS-1:0]     rsp_r20,
   output logic [ELEM_BITS-1:0]     rsp_r21,
   output logic [ELEM_BITS-1:0]     rsp_r22,
   output logic                     rsp_singular,
   input  logic                     psel,
   input  logic                     penable,
   input  logic                     pwrite,
   input  logic [CSR_AW-1:0]        paddr,
   input  logic [CSR_DATA_BITS-1:0] pwdata,
   output logic [CSR_DATA_BITS-1:0] prdata,
   output logic                     pready
);

   logic [THR_BITS-1:0] thr_ff;
   logic                reg_hit;
   mat_type             in_mat;
   mat_type             res_mat;
   logic                f_valid;
   logic                f_ready;
   cls_item_type        f_item;
   logic                b_valid;
   logic                b_ready;
   cls_item_type        b_item;

   assign pready  = 1'b1;
   assign reg_hit = (paddr[CSR_AW-1] == REG_THRESHOLD);
   assign prdata  = reg_hit ? CSR_DATA_BITS'(thr_ff) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff <= THR_RESET;
      end else if (psel && penable && pwrite && pready && reg_hit) begin
         thr_ff <= pwdata[THR_BITS-1:0];
      end
   end

   assign in_mat = {req_a22, req_a21, req_a20, req_a12, req_a11, req_a10,
                    req_a02, req_a01, req_a00};

   mi3_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .in_mat    (in_mat),
      .thr       (thr_ff),
      .out_valid (f_valid),
      .out_ready (f_ready),
      .out_item  (f_item)
   );

   mi3_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (f_valid),
      .push_ready (f_ready),
      .push_item  (f_item),
      .pop_valid  (b_valid),
      .pop_ready  (b_ready),
      .pop_item   (b_item)
   );

   mi3_back u_back (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (b_valid),
      .in_ready  (b_ready),
      .in_item   (b_item),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_mat   (res_mat),
      .out_sing  (rsp_singular)
   );

   assign rsp_r00 = res_mat[0];
   assign rsp_r01 = res_mat[1];
   assign rsp_r02 = res_mat[2];
   assign rsp_r10 = res_mat[3];
   assign rsp_r11 = res_mat[4];
   assign rsp_r12 = res_mat[5];
   assign rsp_r20 = res_mat[6];
   assign rsp_r21 = res_mat[7];
   assign rsp_r22 = res_mat[8];

endmodule
